// ----- hw/rtl/lcps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_pkg: shared types and constants for the LED chase pattern sequencer
// Phase codes, port levels, register indexes and small pattern helpers.
// ----------------------------------------------------------------------------
package lcps_pkg;

    typedef enum logic [2:0] {
        PH_FLASH   = 3'd0,
        PH_CHASE_L = 3'd1,
        PH_CHASE_R = 3'd2,
        PH_FILL_L  = 3'd3,
        PH_FILL_R  = 3'd4
    } phase_t;

    typedef enum logic {
        REG_LONG_HOLD  = 1'b0,
        REG_SHORT_HOLD = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] PORTS_OFF      = 8'hff;
    localparam logic [7:0] PORTS_ON       = 8'h00;
    localparam logic [7:0] FILL_UP_SEED   = 8'hfe;
    localparam logic [7:0] FILL_DOWN_SEED = 8'h7f;
    localparam logic [4:0] FLASH_LAST     = 5'd5;
    localparam logic [4:0] STEP_LAST      = 5'd31;
    localparam logic [7:0] LONG_HOLD_RST  = 8'd5;
    localparam logic [7:0] SHORT_HOLD_RST = 8'd1;

    // single lit LED at bit k (active low)
    function automatic logic [7:0] one_lit(input logic [2:0] k);
        return ~(8'd1 << k);
    endfunction

    // lit from the bottom, growing upward
    function automatic logic [7:0] fill_up(input logic [2:0] m);
        return FILL_UP_SEED << m;
    endfunction

    // lit from the top, growing downward
    function automatic logic [7:0] fill_down(input logic [2:0] m);
        return FILL_DOWN_SEED >> m;
    endfunction

    // position of a port in the left order P1,P3,P2,P0
    function automatic logic [1:0] left_pos(input logic [1:0] port);
        logic [1:0] pos;
        case (port)
            2'd0:    pos = 2'd3;
            2'd1:    pos = 2'd0;
            2'd2:    pos = 2'd2;
            default: pos = 2'd1;
        endcase
        return pos;
    endfunction

    // position of a port in the right order P0,P2,P3,P1
    function automatic logic [1:0] right_pos(input logic [1:0] port);
        logic [1:0] pos;
        case (port)
            2'd0:    pos = 2'd0;
            2'd1:    pos = 2'd3;
            2'd2:    pos = 2'd1;
            default: pos = 2'd2;
        endcase
        return pos;
    endfunction

endpackage

// ----- hw/rtl/lcps_pattern_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_pattern_gen: LED pattern for a phase and step
// Pure decode of phase/step into the four active-low port patterns.
// ----------------------------------------------------------------------------
module lcps_pattern_gen (
    input  lcps_pkg::phase_t phase,
    input  logic [4:0]       step,
    output logic [31:0]      pattern
);
    import lcps_pkg::*;

    logic [1:0] grp;
    logic [2:0] pos_m;
    logic [7:0] chase_l_v;
    logic [7:0] chase_r_v;
    logic [7:0] fill_l_v;
    logic [7:0] fill_r_v;

    assign grp   = step[4:3];
    assign pos_m = step[2:0];

    // last group of the left run and all but the first of the right run go downward
    assign chase_l_v = (grp == 2'd3) ? one_lit(~pos_m) : one_lit(pos_m);
    assign chase_r_v = (grp == 2'd0) ? one_lit(pos_m)  : one_lit(~pos_m);
    assign fill_l_v  = (grp == 2'd3) ? fill_down(pos_m) : fill_up(pos_m);
    assign fill_r_v  = (grp == 2'd0) ? fill_up(pos_m)   : fill_down(pos_m);

    always_comb begin
        logic [1:0] lp;
        logic [1:0] rp;
        pattern = {4{PORTS_OFF}};
        for (int p = 0; p < 4; p++) begin
            lp = left_pos(2'(p));
            rp = right_pos(2'(p));
            case (phase)
                PH_FLASH: begin
                    pattern[p*8 +: 8] = step[0] ? PORTS_OFF : PORTS_ON;
                end
                PH_CHASE_L: begin
                    pattern[p*8 +: 8] = (lp == grp) ? chase_l_v : PORTS_OFF;
                end
                PH_CHASE_R: begin
                    pattern[p*8 +: 8] = (rp == grp) ? chase_r_v : PORTS_OFF;
                end
                PH_FILL_L: begin
                    pattern[p*8 +: 8] = (lp < grp)  ? PORTS_ON :
                                        (lp == grp) ? fill_l_v : PORTS_OFF;
                end
                PH_FILL_R: begin
                    pattern[p*8 +: 8] = (rp < grp)  ? PORTS_ON :
                                        (rp == grp) ? fill_r_v : PORTS_OFF;
                end
                default: begin
                    pattern[p*8 +: 8] = PORTS_OFF;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/led_chase_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_chase_pattern_sequencer: 32-LED flash / chase / fill animation
// Each advancing request is one time tick; every request returns the current
// pattern of the four active-low ports and the animation phase.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | content
//  s_      | in  | s_tvalid/s_tready   | tdata[0] advance
//  m_      | out | m_tvalid/m_tready   | tdata: port0..port3 leds, phase
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (hold registers)
//
//  One request per cycle while s_tready is high; the result appears in the cycle after acceptance.
//  The result is held in the single output register behind the tick/decode logic.
//  aresetn (synchronous) restores flash phase, step 0, all LEDs lit, holds 5/1.
//  A stalled result is held in the output register; s_tready stays high as
//  long as that register is empty or is being taken in the same cycle.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module led_chase_pattern_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] advance, [7:1] zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] port0_leds, [15:8] port1_leds,
                                   // [23:16] port2_leds, [31:24] port3_leds,
                                   // [34:32] phase, [39:35] zero
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import lcps_pkg::*;

    // configuration
    logic [7:0]  long_hold_reg;
    logic [7:0]  short_hold_reg;

    // animation state
    phase_t      phase_reg,   phase_next;
    logic [4:0]  step_reg,    step_next;
    logic [7:0]  hold_cnt_reg, hold_cnt_next;
    logic [31:0] pattern_reg, pattern_next;

    // output stage
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic        s_accept;
    logic        tick;
    logic [7:0]  hold;
    logic [8:0]  hold_cnt_inc;
    logic        step_done;
    logic [31:0] gen_pattern;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign tick      = s_accept && s_tdata[0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_hold_reg  <= LONG_HOLD_RST;
            short_hold_reg <= SHORT_HOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_LONG_HOLD:  long_hold_reg  <= cfg_data;
                REG_SHORT_HOLD: short_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold timing: a hold of zero behaves as one, since count+1 >= 0 always
    assign hold         = (phase_reg == PH_FLASH) ? long_hold_reg : short_hold_reg;
    assign hold_cnt_inc = {1'b0, hold_cnt_reg} + 9'd1;
    assign step_done    = hold_cnt_inc >= {1'b0, hold};

    // Next phase / step
    always_comb begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        hold_cnt_next = hold_cnt_reg;
        if (tick) begin
            if (step_done) begin
                hold_cnt_next = 8'd0;
                step_next     = step_reg + 5'd1;
                case (phase_reg)
                    PH_FLASH: begin
                        if (step_reg >= FLASH_LAST) begin
                            phase_next = PH_CHASE_L;
                            step_next  = 5'd0;
                        end
                    end
                    PH_CHASE_L: begin
                        if (step_reg == STEP_LAST) begin
                            phase_next = PH_CHASE_R;
                        end
                    end
                    PH_CHASE_R: begin
                        if (step_reg == STEP_LAST) begin
                            phase_next = PH_FILL_L;
                        end
                    end
                    PH_FILL_L: begin
                        if (step_reg == STEP_LAST) begin
                            phase_next = PH_FILL_R;
                        end
                    end
                    PH_FILL_R: begin
                        if (step_reg == STEP_LAST) begin
                            phase_next = PH_FLASH;
                        end
                    end
                    default: begin
                        phase_next = PH_FLASH;
                        step_next  = 5'd0;
                    end
                endcase
            end else begin
                hold_cnt_next = hold_cnt_inc[7:0];
            end
        end
    end

    lcps_pattern_gen u_pattern_gen (
        .phase   (phase_next),
        .step    (step_next),
        .pattern (gen_pattern)
    );

    // pattern is only recomputed when a step ends; reads show the stored one
    assign pattern_next = (tick && step_done) ? gen_pattern : pattern_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FLASH;
            step_reg     <= 5'd0;
            hold_cnt_reg <= 8'd0;
            pattern_reg  <= {4{PORTS_ON}};
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            hold_cnt_reg <= hold_cnt_next;
            pattern_reg  <= pattern_next;
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload (no reset needed)
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {5'd0, phase_next, pattern_next};
        end
    end

`ifndef ASSERT_OFF
    // flash phase only walks steps 0..5
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FLASH) |-> (step_reg <= FLASH_LAST))
        else $error("flash step out of range");

    // a read-only request leaves the animation untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tdata[0]) |=>
            ($stable(phase_reg) && $stable(step_reg) && $stable(hold_cnt_reg)
             && $stable(pattern_reg)))
        else $error("read-only request changed state");

    // every accepted request leaves a result waiting next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted request produced no result");
`endif

endmodule
